// File: rtl/assert_macros.svh
// Assertion macros used by banked_memory_mapper.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bmm_pkg.sv
package bmm_pkg;

   // Sizes of the stores.
   localparam int RAM_DEPTH  = 8192;
   localparam int SRAM_DEPTH = 16384;
   localparam int BANK_BITS  = 6;

   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam int SRAM_AW   = $clog2(SRAM_DEPTH);
   localparam int CLR_DEPTH = (RAM_DEPTH > SRAM_DEPTH) ? RAM_DEPTH : SRAM_DEPTH;
   localparam int CLR_AW    = $clog2(CLR_DEPTH);

   localparam int OFFSET_W  = 14;
   localparam int PHYS_W    = 20;
   localparam int LIN_W     = BANK_BITS + OFFSET_W;

   // Bus addresses of interest.
   localparam logic [15:0] ADDR_GLASSES  = 16'hfff8;
   localparam logic [15:0] ADDR_SRAM_CTL = 16'hfffc;
   localparam logic [15:0] ADDR_TOP_S0   = 16'hfffd;
   localparam logic [15:0] ADDR_TOP_S1   = 16'hfffe;
   localparam logic [15:0] ADDR_TOP_S2   = 16'hffff;
   localparam logic [15:0] ADDR_SPLIT_S0 = 16'h0000;
   localparam logic [15:0] ADDR_SPLIT_S1 = 16'h4000;
   localparam logic [15:0] ADDR_SPLIT_S2 = 16'h8000;
   localparam logic [15:0] ADDR_SINGLE   = 16'ha000;
   localparam logic [15:0] ADDR_RAM_BASE = 16'hc000;
   localparam int          PROTECT_SIZE  = (1 << 10);

   localparam logic [7:0] OPEN_BUS_BYTE = 8'hff;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_BIOS_PRESENT = 2'd0;
   localparam logic [1:0] CSR_ROM_PRESENT  = 2'd1;
   localparam logic [1:0] CSR_BIOS_AMASK   = 2'd2;
   localparam logic [1:0] CSR_ROM_AMASK    = 2'd3;

   typedef enum logic [2:0] {
      TGT_BIOS = 3'd0,
      TGT_SRAM = 3'd1,
      TGT_ROM  = 3'd2,
      TGT_RAM  = 3'd3,
      TGT_OPEN = 3'd4
   } target_type;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_TOP     = 2'd1,
      KIND_SPLIT   = 2'd2,
      KIND_SINGLE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      EYE_NONE  = 2'd0,
      EYE_LEFT  = 2'd1,
      EYE_RIGHT = 2'd2
   } eye_type;

   // Where the returned byte comes from.
   typedef enum logic [1:0] {
      RSEL_ZERO = 2'd0,
      RSEL_OPEN = 2'd1,
      RSEL_RAM  = 2'd2,
      RSEL_SRAM = 2'd3
   } rsel_type;

   typedef struct packed {
      logic        req_type;
      logic [15:0] cpu_addr;
      logic [7:0]  wr_data;
      logic [7:0]  mem_control;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  target;
      logic [19:0] phys_addr;
      logic [7:0]  read_byte;
      logic [1:0]  glasses_field;
      logic [1:0]  mapper_kind;
   } rsp_payload_type;

   // Decoded request waiting for its memory read data.
   typedef struct packed {
      target_type  target;
      logic [19:0] phys_addr;
      rsel_type    rsel;
      eye_type     glasses;
      kind_type    kind;
   } decode_type;

endpackage

// File: rtl/banked_memory_mapper.sv
// Banked memory mapper for an 8-bit CPU bus.
//
// Requests arrive on the req_ channel (valid/ready), one CPU memory read or
// write each, and each gives exactly one response on the rsp_ channel: the
// decoded target, the masked physical ROM address, the byte read from work
// RAM or save RAM, and the glasses latch and mapper scheme after the request.
//
// A request is decoded and registered into the decode stage at the edge that
// accepts it, together with its synchronous RAM read; it moves on into the
// response register, raising rsp_valid, once that register is free. After
// the clear, with rsp_ready held high, one request is accepted every cycle.
//
// After reset both RAMs are cleared, one entry a cycle, over CLR_DEPTH
// entries (16384 with the default sizes) while req_ready stays low. The
// configuration port (csr_) accepts writes at any time, the clear included,
// but is meant to be written only when no request is outstanding.
//
// If the receiver holds rsp_ready low, the response register holds its
// value, one further decoded request waits in the decode stage, and then
// req_ready falls until the response is taken.

`include "assert_macros.svh"

module banked_memory_mapper (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bmm_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bmm_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [19:0]              csr_wdata
);

   // Configuration registers.
   logic        bios_present_ff;
   logic        rom_present_ff;
   logic [19:0] bios_amask_ff;
   logic [19:0] rom_amask_ff;

   // Mapper state.
   logic [bmm_pkg::BANK_BITS-1:0] bank_ff [3];
   logic [bmm_pkg::BANK_BITS-1:0] bank_in [3];
   bmm_pkg::kind_type kind_ff, kind_in;
   bmm_pkg::eye_type  eye_ff, eye_in;
   logic              sram_on_ff, sram_on_in;

   // Clearing pass after reset.
   logic                       clearing_ff;
   logic [bmm_pkg::CLR_AW-1:0] clr_ff;

   // The two RAMs and their registered read data.
   logic [7:0] work_ram_mem [bmm_pkg::RAM_DEPTH];
   logic [7:0] save_ram_mem [bmm_pkg::SRAM_DEPTH];
   logic [7:0] ram_q_ff;
   logic [7:0] sram_q_ff;

   logic                        ram_we, ram_re, sram_we, sram_re;
   logic [bmm_pkg::RAM_AW-1:0]  ram_waddr, ram_raddr;
   logic [bmm_pkg::SRAM_AW-1:0] sram_waddr, sram_raddr;
   logic [7:0]                  ram_wdata, sram_wdata;

   // Decode stage and response register.
   logic                     s1_valid_ff;
   bmm_pkg::decode_type      s1_ff, s1_in;
   logic                     rsp_valid_ff;
   bmm_pkg::rsp_payload_type rsp_data_ff;

   logic        accept, out_free, s1_adv;
   logic        is_write;
   logic [15:0] addr;
   logic [13:0] offset;
   logic [1:0]  slot;
   logic [bmm_pkg::BANK_BITS-1:0] slot_bank;
   logic [bmm_pkg::LIN_W-1:0]     lin_addr;
   logic [19:0]                   phys_raw;
   logic        in_sram_window, in_ram_window, sram_write, ram_write;
   logic [15:0] sram_index_wide;
   logic [7:0]  rbyte;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !clearing_ff && (!s1_valid_ff || out_free);
   assign accept    = req_valid && req_ready;

   assign is_write = req_data.req_type;
   assign addr     = req_data.cpu_addr;
   assign offset   = addr[13:0];
   assign slot     = addr[15:14];

   assign in_ram_window  = (addr >= bmm_pkg::ADDR_RAM_BASE);
   assign in_sram_window = (addr >= bmm_pkg::ADDR_SPLIT_S2) && !in_ram_window;
   assign sram_index_wide = {2'b00, offset};

   // Bank selected for a read in the slot area. The first kilobyte of slot 0
   // always reads from bank 0.
   always_comb begin
      case (slot)
         2'd0:    slot_bank = bank_ff[0];
         2'd1:    slot_bank = bank_ff[1];
         2'd2:    slot_bank = bank_ff[2];
         default: slot_bank = '0;
      endcase
      if (slot == 2'd0 && offset < 14'(bmm_pkg::PROTECT_SIZE)) begin
         slot_bank = '0;
      end
   end

   // Bank base plus offset is a plain concatenation, as the offset never
   // reaches the next bank.
   assign lin_addr = {slot_bank, offset};
   assign phys_raw = 20'(lin_addr);

   // Write handling: glasses latch, scheme detection, then the bank and
   // SRAM-enable registers of the scheme now in force.
   always_comb begin
      kind_in    = kind_ff;
      eye_in     = eye_ff;
      sram_on_in = sram_on_ff;
      for (int i = 0; i < 3; i++) begin
         bank_in[i] = bank_ff[i];
      end

      if (accept && is_write) begin
         if (addr >= bmm_pkg::ADDR_GLASSES && addr < bmm_pkg::ADDR_SRAM_CTL) begin
            if (req_data.wr_data[0]) begin
               eye_in = bmm_pkg::EYE_LEFT;
            end else if (eye_ff == bmm_pkg::EYE_LEFT) begin
               eye_in = bmm_pkg::EYE_RIGHT;
            end
         end

         if (kind_ff == bmm_pkg::KIND_UNKNOWN) begin
            if (addr >= bmm_pkg::ADDR_SRAM_CTL) begin
               kind_in = bmm_pkg::KIND_TOP;
            end else if (addr == bmm_pkg::ADDR_SPLIT_S1 || addr == bmm_pkg::ADDR_SPLIT_S2) begin
               kind_in = bmm_pkg::KIND_SPLIT;
            end else if (addr == bmm_pkg::ADDR_SINGLE) begin
               kind_in = bmm_pkg::KIND_SINGLE;
            end
         end

         case (kind_in)
            bmm_pkg::KIND_TOP: begin
               if (addr == bmm_pkg::ADDR_SRAM_CTL) begin
                  sram_on_in = req_data.wr_data[3];
               end else if (addr == bmm_pkg::ADDR_TOP_S0) begin
                  bank_in[0] = req_data.wr_data[bmm_pkg::BANK_BITS-1:0];
               end else if (addr == bmm_pkg::ADDR_TOP_S1) begin
                  bank_in[1] = req_data.wr_data[bmm_pkg::BANK_BITS-1:0];
               end else if (addr == bmm_pkg::ADDR_TOP_S2) begin
                  bank_in[2] = req_data.wr_data[bmm_pkg::BANK_BITS-1:0];
               end
            end
            bmm_pkg::KIND_SPLIT: begin
               if (addr == bmm_pkg::ADDR_SPLIT_S0) begin
                  bank_in[0] = req_data.wr_data[bmm_pkg::BANK_BITS-1:0];
               end else if (addr == bmm_pkg::ADDR_SPLIT_S1) begin
                  bank_in[1] = req_data.wr_data[bmm_pkg::BANK_BITS-1:0];
               end else if (addr == bmm_pkg::ADDR_SPLIT_S2) begin
                  bank_in[2] = req_data.wr_data[bmm_pkg::BANK_BITS-1:0];
               end
            end
            bmm_pkg::KIND_SINGLE: begin
               if (addr == bmm_pkg::ADDR_SINGLE) begin
                  bank_in[2] = req_data.wr_data[bmm_pkg::BANK_BITS-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The SRAM-enable register sits outside the save RAM window, so the
   // current value decides a save RAM write just as the updated one would.
   assign sram_write = is_write && sram_on_ff && in_sram_window;
   assign ram_write  = is_write && in_ram_window;

   // Decoded response fields, short of the RAM read data.
   always_comb begin
      s1_in.target    = bmm_pkg::TGT_OPEN;
      s1_in.phys_addr = '0;
      s1_in.rsel      = bmm_pkg::RSEL_ZERO;
      s1_in.glasses   = eye_in;
      s1_in.kind      = kind_in;

      if (is_write) begin
         if (ram_write) begin
            s1_in.target = bmm_pkg::TGT_RAM;
         end else if (sram_write) begin
            s1_in.target = bmm_pkg::TGT_SRAM;
         end
      end else if (in_ram_window) begin
         s1_in.target = bmm_pkg::TGT_RAM;
         s1_in.rsel   = bmm_pkg::RSEL_RAM;
      end else if (bios_present_ff && !req_data.mem_control[3]) begin
         s1_in.target    = bmm_pkg::TGT_BIOS;
         s1_in.phys_addr = phys_raw & bios_amask_ff;
      end else if (sram_on_ff && slot == 2'd2) begin
         s1_in.target = bmm_pkg::TGT_SRAM;
         s1_in.rsel   = bmm_pkg::RSEL_SRAM;
      end else if (rom_present_ff && !req_data.mem_control[6]) begin
         s1_in.target    = bmm_pkg::TGT_ROM;
         s1_in.phys_addr = phys_raw & rom_amask_ff;
      end else begin
         s1_in.rsel = bmm_pkg::RSEL_OPEN;
      end
   end

   // RAM ports. During the clearing pass both RAMs are swept together; the
   // smaller one simply sees its entries written more than once.
   always_comb begin
      ram_re     = accept && !is_write && in_ram_window;
      ram_raddr  = addr[bmm_pkg::RAM_AW-1:0];
      sram_re    = accept && !is_write && sram_on_ff && slot == 2'd2;
      sram_raddr = sram_index_wide[bmm_pkg::SRAM_AW-1:0];
      if (clearing_ff) begin
         ram_we     = 1'b1;
         ram_waddr  = clr_ff[bmm_pkg::RAM_AW-1:0];
         ram_wdata  = '0;
         sram_we    = 1'b1;
         sram_waddr = clr_ff[bmm_pkg::SRAM_AW-1:0];
         sram_wdata = '0;
      end else begin
         ram_we     = accept && ram_write;
         ram_waddr  = addr[bmm_pkg::RAM_AW-1:0];
         ram_wdata  = req_data.wr_data;
         sram_we    = accept && sram_write;
         sram_waddr = sram_index_wide[bmm_pkg::SRAM_AW-1:0];
         sram_wdata = req_data.wr_data;
      end
   end

   // A read that follows a write of the same entry samples the RAM at a later
   // edge, so the read always sees the stored byte.
   always_ff @(posedge clock) begin
      if (ram_we) begin
         work_ram_mem[ram_waddr] <= ram_wdata;
      end
      if (ram_re) begin
         ram_q_ff <= work_ram_mem[ram_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (sram_we) begin
         save_ram_mem[sram_waddr] <= sram_wdata;
      end
      if (sram_re) begin
         sram_q_ff <= save_ram_mem[sram_raddr];
      end
   end

   // Read data for the response leaving the decode stage.
   always_comb begin
      case (s1_ff.rsel)
         bmm_pkg::RSEL_OPEN: rbyte = bmm_pkg::OPEN_BUS_BYTE;
         bmm_pkg::RSEL_RAM:  rbyte = ram_q_ff;
         bmm_pkg::RSEL_SRAM: rbyte = sram_q_ff;
         default:            rbyte = '0;
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bios_present_ff <= 1'b0;
         rom_present_ff  <= 1'b0;
         bios_amask_ff   <= '1;
         rom_amask_ff    <= '1;
      end else if (csr_we) begin
         case (csr_index)
            bmm_pkg::CSR_BIOS_PRESENT: bios_present_ff <= csr_wdata[0];
            bmm_pkg::CSR_ROM_PRESENT:  rom_present_ff  <= csr_wdata[0];
            bmm_pkg::CSR_BIOS_AMASK:   bios_amask_ff   <= csr_wdata;
            bmm_pkg::CSR_ROM_AMASK:    rom_amask_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Mapper state, clearing pass and handshake control.
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff[0]   <= bmm_pkg::BANK_BITS'(0);
         bank_ff[1]   <= bmm_pkg::BANK_BITS'(1);
         bank_ff[2]   <= bmm_pkg::BANK_BITS'(2);
         kind_ff      <= bmm_pkg::KIND_UNKNOWN;
         eye_ff       <= bmm_pkg::EYE_NONE;
         sram_on_ff   <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < 3; i++) begin
            bank_ff[i] <= bank_in[i];
         end
         kind_ff    <= kind_in;
         eye_ff     <= eye_in;
         sram_on_ff <= sram_on_in;
         if (clearing_ff) begin
            clr_ff <= clr_ff + bmm_pkg::CLR_AW'(1);
            if (clr_ff == bmm_pkg::CLR_AW'(bmm_pkg::CLR_DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_data_ff.target        <= s1_ff.target;
         rsp_data_ff.phys_addr     <= s1_ff.phys_addr;
         rsp_data_ff.read_byte     <= rbyte;
         rsp_data_ff.glasses_field <= s1_ff.glasses;
         rsp_data_ff.mapper_kind   <= s1_ff.kind;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No request may enter while the RAMs are being cleared.
   `ASSERT_ALWAYS(a_no_accept_in_clear, clock, clearing_ff |-> !req_ready,
                  "request accepted during RAM clear")

   // Once detected, the mapper scheme never changes until reset.
   `ASSERT_CLK(a_kind_sticky, clock, reset,
               (kind_ff != bmm_pkg::KIND_UNKNOWN) |=> (kind_ff == $past(kind_ff)),
               "mapper scheme changed after detection")

   // A decoded request blocked by the response register keeps its fields.
   `ASSERT_CLK(a_s1_hold, clock, reset,
               (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_ff)),
               "decode stage lost or changed a waiting request")

endmodule
